// ----- hw/rtl/owtrs_pkg.sv -----
// Package for the one-wire temperature read sequencer.
// Holds the phase type, the register indexes, reset values and the command bytes.
// Has no dependencies.
package owtrs_pkg;

   localparam int WAIT_CNT_BITS = 20;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS = 20;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_RST_LOW     = 4'd1,
      PH_RST_WAIT    = 4'd2,
      PH_RST_RECOVER = 4'd3,
      PH_SLOT_LOW    = 4'd4,
      PH_WRITE_HOLD  = 4'd5,
      PH_READ_WAIT   = 4'd6,
      PH_READ_TAIL   = 4'd7,
      PH_CONVERT     = 4'd8
   } phase_type;

   localparam logic [CSR_INDEX_BITS-1:0] REG_RESET_LOW     = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRESENCE_SMP  = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RESET_RECOVER = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOT_LOW      = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_WRITE_HOLD    = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_READ_SAMPLE   = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_READ_TAIL     = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CONVERT_WAIT  = 4'd7;

   localparam logic [9:0]  RST_RESET_LOW     = 10'd485;
   localparam logic [7:0]  RST_PRESENCE_SMP  = 8'd65;
   localparam logic [9:0]  RST_RESET_RECOVER = 10'd420;
   localparam logic [3:0]  RST_SLOT_LOW      = 4'd2;
   localparam logic [7:0]  RST_WRITE_HOLD    = 8'd65;
   localparam logic [5:0]  RST_READ_SAMPLE   = 6'd13;
   localparam logic [7:0]  RST_READ_TAIL     = 8'd45;
   localparam logic [19:0] RST_CONVERT_WAIT  = 20'd1000000;

   localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
   localparam logic [7:0] CMD_CONVERT      = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   // Byte step numbers of the sequence; only the convert and read-scratchpad steps carry a command other than skip-ROM.
   localparam logic [2:0] STEP_CONVERT      = 3'd1;
   localparam logic [2:0] STEP_WAIT         = 3'd2;
   localparam logic [2:0] STEP_SECOND_RESET = 3'd3;
   localparam logic [2:0] STEP_SECOND_SKIP  = 3'd4;
   localparam logic [2:0] STEP_READ_CMD     = 3'd5;
   localparam logic [2:0] STEP_READ_LOW     = 3'd6;
   localparam logic [2:0] STEP_READ_HIGH    = 3'd7;

   function automatic logic [7:0] byte_for_step(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         STEP_CONVERT:  b = CMD_CONVERT;
         STEP_READ_CMD: b = CMD_READ_SCRATCH;
         default:       b = CMD_SKIP_ROM;
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/onewire_temperature_read_sequencer.sv -----
// An accepted request beat gives its response beat in the next cycle.
// Throughput: one request beat per cycle unless held off; the phase, counter and
// shift register update in the cycle of acceptance and the response register takes
// the result. A request is held off only while a response beat waits under stall.
// Reset (synchronous, active high) returns to idle and loads the register defaults.
// Uses owtrs_pkg for the phase type, register indexes and command bytes.
module onewire_temperature_read_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic                                req_line_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drive_low,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_present,
   output logic [15:0]                         rsp_temperature_raw,
   input  logic                                csr_write_en,
   input  logic [owtrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [owtrs_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [9:0]  cfg_reset_low_ff;
   logic [7:0]  cfg_presence_smp_ff;
   logic [9:0]  cfg_reset_recover_ff;
   logic [3:0]  cfg_slot_low_ff;
   logic [7:0]  cfg_write_hold_ff;
   logic [5:0]  cfg_read_sample_ff;
   logic [7:0]  cfg_read_tail_ff;
   logic [19:0] cfg_convert_wait_ff;

   owtrs_pkg::phase_type phase_ff, phase_in;
   logic [owtrs_pkg::WAIT_CNT_BITS-1:0] tick_ff, tick_in, tick_inc, limit;
   logic [2:0]  bit_ff, bit_in;
   logic [2:0]  step_ff, step_in;
   logic [15:0] shift_ff, shift_in;
   logic        present_ff, present_in;
   logic        done_in, drive_in, reached;
   logic [3:0]  read_pos;
   logic [7:0]  tx_byte;

   logic        rsp_valid_ff;
   logic        drive_ff, busy_ff, done_ff;
   logic        req_accept;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_reset_low_ff     <= owtrs_pkg::RST_RESET_LOW;
         cfg_presence_smp_ff  <= owtrs_pkg::RST_PRESENCE_SMP;
         cfg_reset_recover_ff <= owtrs_pkg::RST_RESET_RECOVER;
         cfg_slot_low_ff      <= owtrs_pkg::RST_SLOT_LOW;
         cfg_write_hold_ff    <= owtrs_pkg::RST_WRITE_HOLD;
         cfg_read_sample_ff   <= owtrs_pkg::RST_READ_SAMPLE;
         cfg_read_tail_ff     <= owtrs_pkg::RST_READ_TAIL;
         cfg_convert_wait_ff  <= owtrs_pkg::RST_CONVERT_WAIT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            owtrs_pkg::REG_RESET_LOW:     cfg_reset_low_ff     <= csr_write_data[9:0];
            owtrs_pkg::REG_PRESENCE_SMP:  cfg_presence_smp_ff  <= csr_write_data[7:0];
            owtrs_pkg::REG_RESET_RECOVER: cfg_reset_recover_ff <= csr_write_data[9:0];
            owtrs_pkg::REG_SLOT_LOW:      cfg_slot_low_ff      <= csr_write_data[3:0];
            owtrs_pkg::REG_WRITE_HOLD:    cfg_write_hold_ff    <= csr_write_data[7:0];
            owtrs_pkg::REG_READ_SAMPLE:   cfg_read_sample_ff   <= csr_write_data[5:0];
            owtrs_pkg::REG_READ_TAIL:     cfg_read_tail_ff     <= csr_write_data[7:0];
            owtrs_pkg::REG_CONVERT_WAIT:  cfg_convert_wait_ff  <= csr_write_data[19:0];
            default: ;
         endcase
      end
   end

   // Limit of the counter in the present phase.
   always_comb begin
      case (phase_ff)
         owtrs_pkg::PH_RST_LOW:     limit = 20'(cfg_reset_low_ff);
         owtrs_pkg::PH_RST_WAIT:    limit = 20'(cfg_presence_smp_ff);
         owtrs_pkg::PH_RST_RECOVER: limit = 20'(cfg_reset_recover_ff);
         owtrs_pkg::PH_SLOT_LOW:    limit = 20'(cfg_slot_low_ff);
         owtrs_pkg::PH_WRITE_HOLD:  limit = 20'(cfg_write_hold_ff);
         owtrs_pkg::PH_READ_WAIT:   limit = 20'(cfg_read_sample_ff);
         owtrs_pkg::PH_READ_TAIL:   limit = 20'(cfg_read_tail_ff);
         owtrs_pkg::PH_CONVERT:     limit = cfg_convert_wait_ff;
         default:                   limit = '0;
      endcase
   end

   assign tick_inc = tick_ff + 1'b1;
   assign reached  = tick_inc >= limit;
   assign read_pos = {(step_ff == owtrs_pkg::STEP_READ_HIGH), bit_ff};

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      step_in    = step_ff;
      shift_in   = shift_ff;
      present_in = present_ff;
      done_in    = 1'b0;

      if (req_cmd) begin
         if (phase_ff == owtrs_pkg::PH_IDLE) begin
            bit_in     = '0;
            step_in    = '0;
            shift_in   = '0;
            present_in = 1'b0;
            phase_in   = owtrs_pkg::PH_RST_LOW;
            tick_in    = '0;
         end
      end else if (phase_ff != owtrs_pkg::PH_IDLE) begin
         tick_in = tick_inc;
         if (reached) begin
            tick_in = '0;
            unique case (phase_ff) inside
               owtrs_pkg::PH_RST_LOW: phase_in = owtrs_pkg::PH_RST_WAIT;
               owtrs_pkg::PH_RST_WAIT: begin
                  // Only the first reset decides whether a device is there.
                  if (step_ff == '0) present_in = ~req_line_level;
                  phase_in = owtrs_pkg::PH_RST_RECOVER;
               end
               owtrs_pkg::PH_RST_RECOVER: begin
                  if (step_ff == '0) begin
                     if (present_ff) begin
                        phase_in = owtrs_pkg::PH_SLOT_LOW;
                     end else begin
                        shift_in = '0;
                        phase_in = owtrs_pkg::PH_IDLE;
                        done_in  = 1'b1;
                     end
                  end else begin
                     step_in  = owtrs_pkg::STEP_SECOND_SKIP;
                     bit_in   = '0;
                     phase_in = owtrs_pkg::PH_SLOT_LOW;
                  end
               end
               owtrs_pkg::PH_SLOT_LOW: begin
                  if (step_ff >= owtrs_pkg::STEP_READ_LOW) phase_in = owtrs_pkg::PH_READ_WAIT;
                  else phase_in = owtrs_pkg::PH_WRITE_HOLD;
               end
               owtrs_pkg::PH_READ_WAIT: begin
                  shift_in[read_pos] = req_line_level;
                  phase_in = owtrs_pkg::PH_READ_TAIL;
               end
               owtrs_pkg::PH_WRITE_HOLD, owtrs_pkg::PH_READ_TAIL: begin
                  // End of slot: next bit, next byte, convert wait or sequence end.
                  bit_in = bit_ff + 1'b1;
                  if (bit_ff != 3'd7) begin
                     phase_in = owtrs_pkg::PH_SLOT_LOW;
                  end else if (step_ff == owtrs_pkg::STEP_READ_HIGH) begin
                     step_in  = '0;
                     phase_in = owtrs_pkg::PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     step_in = step_ff + 1'b1;
                     if (step_in == owtrs_pkg::STEP_WAIT) phase_in = owtrs_pkg::PH_CONVERT;
                     else phase_in = owtrs_pkg::PH_SLOT_LOW;
                  end
               end
               owtrs_pkg::PH_CONVERT: begin
                  step_in  = owtrs_pkg::STEP_SECOND_RESET;
                  bit_in   = '0;
                  phase_in = owtrs_pkg::PH_RST_LOW;
               end
               default: phase_in = owtrs_pkg::PH_IDLE;
            endcase
         end
      end
   end

   assign tx_byte = owtrs_pkg::byte_for_step(step_in);

   always_comb begin
      case (phase_in) inside
         owtrs_pkg::PH_RST_LOW, owtrs_pkg::PH_SLOT_LOW: drive_in = 1'b1;
         owtrs_pkg::PH_WRITE_HOLD: drive_in = ~tx_byte[bit_in];
         default: drive_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= owtrs_pkg::PH_IDLE;
         tick_ff    <= '0;
         bit_ff     <= '0;
         step_ff    <= '0;
         shift_ff   <= '0;
         present_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         step_ff    <= step_in;
         shift_ff   <= shift_in;
         present_ff <= present_in;
      end
   end

   // Response register: a new beat loads whenever the previous one is gone or leaving.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         drive_ff <= drive_in;
         busy_ff  <= (phase_in != owtrs_pkg::PH_IDLE);
         done_ff  <= done_in;
      end
   end

   logic        rsp_present_ff;
   logic [15:0] rsp_temp_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_present_ff <= present_in;
         rsp_temp_ff    <= shift_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_low       = drive_ff;
   assign rsp_busy_res        = busy_ff;
   assign rsp_done_res        = done_ff;
   assign rsp_present         = rsp_present_ff;
   assign rsp_temperature_raw = rsp_temp_ff;

`ifndef SYNTH
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff)
      else $error("completing beat still reports busy");

   a_drive_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff |-> busy_ff)
      else $error("bus driven low outside a sequence");

   a_start_drives: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_cmd && phase_ff == owtrs_pkg::PH_IDLE
      |=> rsp_valid_ff && busy_ff && drive_ff)
      else $error("start did not open a reset pulse");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff && !rsp_present_ff |-> rsp_temp_ff == 16'd0)
      else $error("absent device gave a non-zero reading");
`endif

endmodule
